// ===== rtl/nec_ir_pulse_decoder_core_defines.svh =====
// Assertion macros shared by the NEC IR pulse decoder RTL.
`ifndef NEC_IR_PULSE_DECODER_CORE_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define NIRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define NIRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nirp_pkg.sv =====
// Types and constants for the NEC IR pulse decoder.
package nirp_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BCNT_W  = 5;

  // Depth of the class queue and of the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Open duration windows in us: lo < d < hi.
  localparam logic [DUR_W-1:0] LEAD_MARK_MIN  = DUR_W'(9000 - 900);
  localparam logic [DUR_W-1:0] LEAD_MARK_MAX  = DUR_W'(9000 + 900);
  localparam logic [DUR_W-1:0] LEAD_SPACE_MIN = DUR_W'(4500 - 450);
  localparam logic [DUR_W-1:0] LEAD_SPACE_MAX = DUR_W'(4500 + 450);
  localparam logic [DUR_W-1:0] RPT_SPACE_MIN  = DUR_W'(2500 - 350);
  localparam logic [DUR_W-1:0] RPT_SPACE_MAX  = DUR_W'(2500 + 250);
  localparam logic [DUR_W-1:0] MARK_MIN       = DUR_W'(560 - 100);
  localparam logic [DUR_W-1:0] MARK_MAX       = DUR_W'(560 + 100);
  localparam logic [DUR_W-1:0] ONE_SPACE_MIN  = DUR_W'(1690 - 200);
  localparam logic [DUR_W-1:0] ONE_SPACE_MAX  = DUR_W'(1690 + 200);
  localparam logic [DUR_W-1:0] ZERO_SPACE_MIN = DUR_W'(560 - 100);
  localparam logic [DUR_W-1:0] ZERO_SPACE_MAX = DUR_W'(560 + 100);

  localparam logic [8:0]        CHECK_SUM = 9'h0FF;
  localparam logic [BCNT_W-1:0] LAST_BIT  = BCNT_W'(31);

  // Pulse classes; all windows of one level are disjoint.
  typedef enum logic [2:0] {
    CLS_LEAD_MARK,
    CLS_SHORT_MARK,
    CLS_LEAD_SPACE,
    CLS_RPT_SPACE,
    CLS_ZERO_SPACE,
    CLS_ONE_SPACE,
    CLS_OTHER
  } pulse_cls_e;

  typedef enum logic [2:0] {
    PH_LEAD_MARK  = 3'd0,
    PH_LEAD_SPACE = 3'd1,
    PH_RPT_MARK   = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_MARK  = 3'd5
  } phase_e;

  // Front to back: head of the class queue.
  typedef struct packed {
    logic       valid;
    pulse_cls_e cls;
  } cls_req_t;

  // Back to result queue: one decoded word.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic              rpt;
  } res_t;

endpackage

// ===== rtl/nirp_front.sv =====
// Front end: classifies each pulse against the windows and queues the class.
module nirp_front
  import nirp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             mark_level_i,
  input  logic [DUR_W-1:0] duration_us_i,
  output logic             full_o,
  output cls_req_t         req_o,
  input  logic             take_i
);

  pulse_cls_e              cls;
  pulse_cls_e              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  logic                    wr_en, rd_en;

  function automatic logic in_win(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                  logic [DUR_W-1:0] hi);
    return (d > lo) && (d < hi);
  endfunction

  always_comb begin
    cls = CLS_OTHER;
    if (mark_level_i) begin
      if (in_win(duration_us_i, LEAD_MARK_MIN, LEAD_MARK_MAX)) cls = CLS_LEAD_MARK;
      else if (in_win(duration_us_i, MARK_MIN, MARK_MAX))      cls = CLS_SHORT_MARK;
    end else begin
      if (in_win(duration_us_i, LEAD_SPACE_MIN, LEAD_SPACE_MAX))      cls = CLS_LEAD_SPACE;
      else if (in_win(duration_us_i, RPT_SPACE_MIN, RPT_SPACE_MAX))   cls = CLS_RPT_SPACE;
      else if (in_win(duration_us_i, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) cls = CLS_ZERO_SPACE;
      else if (in_win(duration_us_i, ONE_SPACE_MIN, ONE_SPACE_MAX))   cls = CLS_ONE_SPACE;
    end
  end

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign wr_en      = push_i && !full_o;
  assign req_o.valid = (cnt_q != '0);
  assign req_o.cls   = mem_q[rd_q];
  assign rd_en      = take_i && req_o.valid;

  always_comb begin
    wr_d  = wr_en ? ((wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = rd_en ? ((rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

// ===== rtl/nirp_back.sv =====
// Back end: frame state machine, shift register and checksum test.
module nirp_back
  import nirp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cls_req_t req_i,
  output logic     take_o,
  input  logic     res_ready_i,
  output res_t     res_o
);

  phase_e             phase_q, phase_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic               check_ok;
  logic               bit_val;

  assign take_o   = req_i.valid && res_ready_i;
  assign check_ok = ({1'b0, word_q[23:16]} + {1'b0, word_q[31:24]}) == CHECK_SUM;
  assign bit_val  = (req_i.cls == CLS_ONE_SPACE);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (take_o) begin
      case (phase_q)
        PH_LEAD_MARK: begin
          if (req_i.cls == CLS_LEAD_MARK) phase_d = PH_LEAD_SPACE;
        end
        PH_LEAD_SPACE: begin
          if (req_i.cls == CLS_LEAD_SPACE)     phase_d = PH_BIT_MARK;
          else if (req_i.cls == CLS_RPT_SPACE) phase_d = PH_RPT_MARK;
          else                                 phase_d = PH_LEAD_MARK;
        end
        PH_RPT_MARK, PH_STOP_MARK: begin
          phase_d = PH_LEAD_MARK;
        end
        PH_BIT_MARK: begin
          phase_d = (req_i.cls == CLS_SHORT_MARK) ? PH_BIT_SPACE : PH_LEAD_MARK;
        end
        PH_BIT_SPACE: begin
          if (req_i.cls == CLS_ZERO_SPACE || req_i.cls == CLS_ONE_SPACE) begin
            phase_d = (bcnt_q >= LAST_BIT) ? PH_STOP_MARK : PH_BIT_MARK;
          end else begin
            phase_d = PH_LEAD_MARK;
          end
        end
        default: phase_d = PH_LEAD_MARK;
      endcase
    end
  end

  // Word, bit count and result.
  always_comb begin
    word_d      = word_q;
    bcnt_d      = bcnt_q;
    res_o.valid = 1'b0;
    res_o.word  = word_q;
    res_o.rpt   = 1'b0;
    if (take_o) begin
      case (phase_q)
        PH_LEAD_MARK: begin
          // idle: stray pulses are dropped, kept word stays
        end
        PH_LEAD_SPACE: begin
          if (req_i.cls != CLS_RPT_SPACE) begin
            word_d = '0;
            bcnt_d = '0;
          end
        end
        PH_RPT_MARK, PH_STOP_MARK: begin
          if (req_i.cls == CLS_SHORT_MARK && check_ok) begin
            res_o.valid = 1'b1;
            res_o.rpt   = (phase_q == PH_RPT_MARK);
          end else begin
            word_d = '0;
            bcnt_d = '0;
          end
        end
        PH_BIT_MARK: begin
          if (req_i.cls != CLS_SHORT_MARK) begin
            word_d = '0;
            bcnt_d = '0;
          end
        end
        PH_BIT_SPACE: begin
          if (req_i.cls == CLS_ZERO_SPACE || req_i.cls == CLS_ONE_SPACE) begin
            word_d = word_q | (WORD_W'(bit_val) << bcnt_q);
            bcnt_d = (bcnt_q >= LAST_BIT) ? '0 : bcnt_q + 1'b1;
          end else begin
            word_d = '0;
            bcnt_d = '0;
          end
        end
        default: begin
          word_d = '0;
          bcnt_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD_MARK;
      word_q  <= '0;
      bcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      word_q  <= word_d;
      bcnt_q  <= bcnt_d;
    end
  end

endmodule

// ===== rtl/nec_ir_pulse_decoder_core.sv =====
// NEC IR decoder: pulse words in, decoded frame words out through a result queue.
// Flow: a pushed pulse word is classified and written into the class queue; the state
// machine takes it while the result queue has room and writes each frame word there.
// Throughput: one pulse word per cycle while the result queue has room.
// Reset: rst_ni low clears both queues and returns to waiting for a leader mark.
module nec_ir_pulse_decoder_core
  import nirp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // pulse side
  input  logic              push_i,
  output logic              full_o,
  input  logic              mark_level_i,
  input  logic [DUR_W-1:0]  duration_us_i,
  // frame side
  output logic              empty_o,
  input  logic              pop_i,
  output logic [WORD_W-1:0] frame_word_o,
  output logic              is_repeat_o
);

`include "nec_ir_pulse_decoder_core_defines.svh"

  cls_req_t cls_req;
  logic     take;
  res_t     res;
  logic     res_ready;

  // Front: window compares and a short class queue, so the pulse side keeps flowing,
  // until that queue fills, while the back end waits on the result queue.
  nirp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .mark_level_i  (mark_level_i),
    .duration_us_i (duration_us_i),
    .full_o        (full_o),
    .req_o         (cls_req),
    .take_i        (take)
  );

  // Back: frame state machine; stalls only while the result queue is full.
  nirp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (cls_req),
    .take_o      (take),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Result queue: decouples frame pops from the state machine.
  logic [WORD_W-1:0] word_mem_q [QUEUE_DEPTH];
  logic              rpt_mem_q  [QUEUE_DEPTH];
  logic [QPTR_W-1:0] owr_q, owr_d, ord_q, ord_d;
  logic [QCNT_W-1:0] ocnt_q, ocnt_d;
  logic              owr_en, ord_en;

  assign res_ready    = (ocnt_q != QCNT_W'(QUEUE_DEPTH));
  assign empty_o      = (ocnt_q == '0);
  assign owr_en       = res.valid;
  assign ord_en       = pop_i && !empty_o;
  assign frame_word_o = word_mem_q[ord_q];
  assign is_repeat_o  = rpt_mem_q[ord_q];

  always_comb begin
    owr_d  = owr_en ? ((owr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : owr_q + 1'b1) : owr_q;
    ord_d  = ord_en ? ((ord_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ord_q + 1'b1) : ord_q;
    ocnt_d = ocnt_q + QCNT_W'(owr_en) - QCNT_W'(ord_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      owr_q  <= owr_d;
      ord_q  <= ord_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr_en) begin
      word_mem_q[owr_q] <= res.word;
      rpt_mem_q[owr_q]  <= res.rpt;
    end
  end

  // A result is only produced when the queue has room for it.
  `NIRP_ASSERT_NOW(a_res_has_room, res.valid, res_ready, "result written into full queue")
  // A fresh result leaves the queue non-empty on the next cycle.
  `NIRP_ASSERT_NEXT(a_res_visible, res.valid, !empty_o, "written result not visible")
  // The back end only takes a class word that the front presents.
  `NIRP_ASSERT_NOW(a_take_valid, take, cls_req.valid, "class word taken from empty queue")
  // Occupancy never exceeds the result queue depth.
  `NIRP_ASSERT_NOW(a_ocnt_range, 1'b1, ocnt_q <= QCNT_W'(QUEUE_DEPTH), "result count overflow")

endmodule

// ===== tb/nec_ir_pulse_decoder_core_tb.sv =====
// Self-checking testbench for the NEC IR pulse decoder core.
module nec_ir_pulse_decoder_core_tb
  import nirp_pkg::*;
();

  // Open timing windows in us (lo < d < hi), kept apart from the RTL package
  // so that a wrong package constant shows up as a mismatch.
  localparam int LEAD_LO = 8100;
  localparam int LEAD_HI = 9900;
  localparam int HDR_LO  = 4050;
  localparam int HDR_HI  = 4950;
  localparam int RPT_LO  = 2150;
  localparam int RPT_HI  = 2750;
  localparam int MK_LO   = 460;
  localparam int MK_HI   = 660;
  localparam int ONE_LO  = 1490;
  localparam int ONE_HI  = 1890;
  localparam int ZERO_LO = 460;
  localparam int ZERO_HI = 660;

  localparam int PULSE_GOAL  = 1350;    // random pulse words
  localparam int FRAME_GOAL  = 48;      // keep going until this many frames were due
  localparam int HOLD_CYCLES = 600;     // long sink stall that fills the result queue
  localparam int DRAIN_TAIL  = 8;       // settle time after the last frame word
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              rpt;
  } frame_t;

  // Tracks the decoder state and holds the frame words still owed by the DUT.
  class frame_scoreboard;
    phase_e            phase;
    logic [WORD_W-1:0] shift_word;
    logic [4:0]        bit_cnt;
    frame_t            owed[$];
    int                mismatches;
    int                frames_due;

    function new();
      clear_decoder();
      mismatches = 0;
      frames_due = 0;
    endfunction

    function void clear_decoder();
      phase      = PH_LEAD_MARK;
      shift_word = '0;
      bit_cnt    = '0;
    endfunction

    function bit fits(logic [DUR_W-1:0] d, int lo, int hi);
      return (int'(d) > lo) && (int'(d) < hi);
    endfunction

    // Advance the decoder by one accepted pulse word.
    function void note_pulse(logic mark, logic [DUR_W-1:0] dur);
      bit     ok;
      bit     rpt;
      logic [8:0] sum;
      frame_t f;
      ok = 1'b0;
      case (phase)
        PH_LEAD_MARK: begin
          // anything but a leader mark is ignored here, the kept word stays
          if (mark && fits(dur, LEAD_LO, LEAD_HI)) phase = PH_LEAD_SPACE;
          ok = 1'b1;
        end
        PH_LEAD_SPACE: begin
          if (!mark) begin
            if (fits(dur, HDR_LO, HDR_HI)) begin
              clear_decoder();
              phase = PH_BIT_MARK;
              ok    = 1'b1;
            end else if (fits(dur, RPT_LO, RPT_HI)) begin
              phase = PH_RPT_MARK;
              ok    = 1'b1;
            end
          end
        end
        PH_RPT_MARK, PH_STOP_MARK: begin
          if (mark && fits(dur, MK_LO, MK_HI)) begin
            rpt   = (phase == PH_RPT_MARK);
            phase = PH_LEAD_MARK;
            ok    = 1'b1;
            sum   = {1'b0, shift_word[23:16]} + {1'b0, shift_word[31:24]};
            if (sum == 9'h0FF) begin
              f.word = shift_word;
              f.rpt  = rpt;
              owed.push_back(f);
              frames_due++;
            end else begin
              clear_decoder();
            end
          end
        end
        PH_BIT_MARK: begin
          if (mark && fits(dur, MK_LO, MK_HI)) begin
            phase = PH_BIT_SPACE;
            ok    = 1'b1;
          end
        end
        PH_BIT_SPACE: begin
          if (!mark && (fits(dur, ZERO_LO, ZERO_HI) || fits(dur, ONE_LO, ONE_HI))) begin
            ok = 1'b1;
            if (fits(dur, ONE_LO, ONE_HI)) shift_word[bit_cnt] = 1'b1;
            if (bit_cnt == 5'd31) begin
              bit_cnt = '0;
              phase   = PH_STOP_MARK;
            end else begin
              bit_cnt = bit_cnt + 5'd1;
              phase   = PH_BIT_MARK;
            end
          end
        end
        default: ;
      endcase
      if (!ok) clear_decoder();
    endfunction

    // Compare one popped frame word with the oldest one owed.
    function void check_frame(logic [WORD_W-1:0] word, logic rpt);
      frame_t f;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame word %08h rpt %0b", word, rpt);
        return;
      end
      f = owed.pop_front();
      if (word !== f.word || rpt !== f.rpt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame mismatch: exp %08h rpt %0b, got %08h rpt %0b",
                   f.word, f.rpt, word, rpt);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              push_i;
  logic              full_o;
  logic              mark_level_i;
  logic [DUR_W-1:0]  duration_us_i;
  logic              empty_o;
  logic              pop_i;
  logic [WORD_W-1:0] frame_word_o;
  logic              is_repeat_o;

  frame_scoreboard sb = new();

  int sent;        // accepted pulse words
  int cycles;
  bit hold_off;    // sender asks the sink for one long stall
  bit calm;        // stretch with no idling on either side

  nec_ir_pulse_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .mark_level_i  (mark_level_i),
    .duration_us_i (duration_us_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .frame_word_o  (frame_word_o),
    .is_repeat_o   (is_repeat_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake or a lost frame word ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Duration inside an open window, with the edge values now and then.
  function automatic logic [DUR_W-1:0] win_dur(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DUR_W'(lo + 1);
    if (r == 1) return DUR_W'(hi - 1);
    return DUR_W'($urandom_range(lo + 1, hi - 1));
  endfunction

  // Duration that misses the window: its bounds or well outside.
  function automatic logic [DUR_W-1:0] bad_dur(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return DUR_W'(lo);
      1:       return DUR_W'(hi);
      2:       return DUR_W'($urandom_range(0, lo));
      default: return DUR_W'($urandom_range(hi, 65535));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] noise_dur();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DUR_W'($urandom_range(400, 10000));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // Offer one pulse word; called and returns at a falling edge.
  task automatic push_pulse(logic mark, logic [DUR_W-1:0] dur);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      push_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push_i        = 1'b1;
    mark_level_i  = mark;
    duration_us_i = dur;
    do @(posedge clk_i); while (full_o);
    sb.note_pulse(mark, dur);
    sent++;
    @(negedge clk_i);
  endtask

  // One symbol of a sequence; at the break position it is spoiled instead.
  task automatic send_sym(int pos, int brk, logic mark, int lo, int hi, output bit stop);
    stop = (pos == brk);
    if (!stop) push_pulse(mark, win_dur(lo, hi));
    else if ($urandom_range(0, 1)) push_pulse(!mark, win_dur(lo, hi));
    else push_pulse(mark, bad_dur(lo, hi));
  endtask

  // Full frame: leader, header space, 32 bits LSB first, stop mark (67 pulses).
  task automatic send_frame(logic [WORD_W-1:0] word, int brk);
    bit stop;
    send_sym(0, brk, 1'b1, LEAD_LO, LEAD_HI, stop);
    if (stop) return;
    send_sym(1, brk, 1'b0, HDR_LO, HDR_HI, stop);
    if (stop) return;
    for (int i = 0; i < 32; i++) begin
      send_sym(2 + 2 * i, brk, 1'b1, MK_LO, MK_HI, stop);
      if (stop) return;
      if (word[i]) send_sym(3 + 2 * i, brk, 1'b0, ONE_LO, ONE_HI, stop);
      else send_sym(3 + 2 * i, brk, 1'b0, ZERO_LO, ZERO_HI, stop);
      if (stop) return;
    end
    send_sym(66, brk, 1'b1, MK_LO, MK_HI, stop);
  endtask

  // Repeat code: leader mark, short space, mark.
  task automatic send_repeat(int brk);
    bit stop;
    send_sym(0, brk, 1'b1, LEAD_LO, LEAD_HI, stop);
    if (stop) return;
    send_sym(1, brk, 1'b0, RPT_LO, RPT_HI, stop);
    if (stop) return;
    send_sym(2, brk, 1'b1, MK_LO, MK_HI, stop);
  endtask

  // Random address; the inverted command is usually right, sometimes not.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [7:0] cmd;
    logic [7:0] inv;
    cmd = 8'($urandom);
    inv = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ~cmd;
    return {inv, cmd, 16'($urandom)};
  endfunction

  task automatic wait_drained();
    push_i = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
  endtask

  // Frame sink: random pop gaps, plus one long stall on request.
  initial begin : frame_sink
    int stall;
    stall = 0;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        pop_i = 1'b0;
        stall--;
      end else begin
        pop_i = 1'b1;
        stall = gap_len();
      end
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_frame(frame_word_o, is_repeat_o);
    end
  end

  // Pulse source: directed corner cases, then random frames, repeats and noise.
  initial begin : pulse_source
    int  r;
    int  brk;
    bit  pressed;
    bit  drained_mid;
    logic [7:0] cmd;
    sent          = 0;
    cycles        = 0;
    hold_off      = 1'b0;
    calm          = 1'b0;
    pressed       = 1'b0;
    drained_mid   = 1'b0;
    push_i        = 1'b0;
    mark_level_i  = 1'b0;
    duration_us_i = '0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle phase: zero, all-ones, a window bound and a wrong level are ignored.
    push_pulse(1'b0, 16'd0);
    push_pulse(1'b1, 16'hFFFF);
    push_pulse(1'b1, DUR_W'(LEAD_LO));
    push_pulse(1'b0, 16'd9000);
    // leader at its low edge, header space at its upper bound -> error
    push_pulse(1'b1, DUR_W'(LEAD_LO + 1));
    push_pulse(1'b0, DUR_W'(HDR_HI));
    // repeat space exactly on its lower bound -> error
    push_pulse(1'b1, DUR_W'(LEAD_HI - 1));
    push_pulse(1'b0, DUR_W'(RPT_LO));
    // repeat space ok, mark on its upper bound -> error
    push_pulse(1'b1, 16'd9000);
    push_pulse(1'b0, DUR_W'(RPT_LO + 1));
    push_pulse(1'b1, DUR_W'(MK_HI));
    // repeat with nothing kept: check fails, nothing comes out
    push_pulse(1'b1, 16'd9000);
    push_pulse(1'b0, DUR_W'(RPT_HI - 1));
    push_pulse(1'b1, DUR_W'(MK_LO + 1));
    // wrong level while a space is due
    push_pulse(1'b1, 16'd9000);
    push_pulse(1'b1, 16'd4500);
    // wrong level while a bit mark is due
    push_pulse(1'b1, 16'd9000);
    push_pulse(1'b0, DUR_W'(HDR_LO + 1));
    push_pulse(1'b0, 16'd560);
    // one bit in, then a zero space on its lower bound -> error
    push_pulse(1'b1, 16'd9000);
    push_pulse(1'b0, DUR_W'(HDR_HI - 1));
    push_pulse(1'b1, DUR_W'(MK_HI - 1));
    push_pulse(1'b0, DUR_W'(ONE_HI - 1));
    push_pulse(1'b1, DUR_W'(MK_LO + 1));
    push_pulse(1'b0, DUR_W'(ZERO_LO));
    wait_drained();

    sent = 0;
    while (sent < PULSE_GOAL || sb.frames_due < FRAME_GOAL) begin
      // Sink stalls long while good frames and repeats keep coming: the
      // result queue fills and full_o backs up the pulse side.
      if (!pressed && sent > PULSE_GOAL / 3) begin
        pressed  = 1'b1;
        calm     = 1'b1;
        hold_off = 1'b1;
        cmd      = 8'($urandom);
        send_frame({~cmd, cmd, 16'($urandom)}, -1);
        repeat (20) send_repeat(-1);
      end
      if (!drained_mid && sent > 2 * PULSE_GOAL / 3) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 66) : -1;
        send_frame(rand_word(), brk);
        repeat ($urandom_range(0, 3))
          send_repeat(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : -1);
      end else if (r < 70) begin
        send_repeat(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : -1);
      end else begin
        repeat ($urandom_range(1, 4)) push_pulse(1'($urandom), noise_dur());
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk_i);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
